@@ rtl/beep_pattern_sequencer_assert.svh @@
// Assertion macros shared by the checker of the buzzer pattern sequencer.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BEEP_PATTERN_SEQUENCER_ASSERT_SVH
`define BEEP_PATTERN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define BPS_ASSERT_IMP(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define BPS_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ rtl/bps_pkg.sv @@
// Shared types and constants of the buzzer pattern sequencer.
// No dependencies; every other file of the block but the assertion header imports this package.
package bps_pkg;

    localparam int unsigned CLOCK_HZ_DEFAULT = 8000000;
    // The tone timer prescale is 32 * 2, for two toggles per tone period.
    localparam int unsigned TONE_PRESCALE = 32 * 2;

    localparam logic       CMD_TICK  = 1'b0;
    localparam logic       CMD_START = 1'b1;

    localparam int unsigned ADDR_W = 4;

    localparam logic        BEEP_ENABLE_RST  = 1'b1;
    localparam logic [7:0]  TICK_STEP_RST    = 8'd10;
    localparam logic [15:0] FREQ_MIN_RST     = 16'd500;
    localparam logic [15:0] FREQ_MAX_RST     = 16'd8000;

    typedef enum logic [1:0] {
        REG_BEEP_ENABLE = 2'd0,
        REG_TICK_STEP   = 2'd1,
        REG_FREQ_MIN    = 2'd2,
        REG_FREQ_MAX    = 2'd3
    } bps_reg_idx_t;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ARMED = 2'd1,
        PH_BEEP  = 2'd2,
        PH_PAUSE = 2'd3
    } bps_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_COMMIT
    } bps_state_t;

    typedef struct packed {
        logic        beep_enable;
        logic [7:0]  tick_step_ms;
        logic [15:0] freq_min_hz;
        logic [15:0] freq_max_hz;
    } bps_cfg_t;

    typedef struct packed {
        logic latch;
        logic div_start;
        logic div_step;
        logic commit;
    } bps_cmd_t;

    typedef struct packed {
        logic armed;
        logic div_done;
        logic out_free;
    } bps_status_t;

endpackage

@@ rtl/bps_cfg.sv @@
// APB-style configuration registers of the buzzer pattern sequencer.
// Depends on bps_pkg for register indexes, reset values and the config struct.
module bps_cfg import bps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output bps_cfg_t          cfg
);

    logic         beep_enable_reg;
    logic [7:0]   tick_step_reg;
    logic [15:0]  freq_min_reg;
    logic [15:0]  freq_max_reg;
    logic         wr_en;
    bps_reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = bps_reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beep_enable_reg <= BEEP_ENABLE_RST;
            tick_step_reg   <= TICK_STEP_RST;
            freq_min_reg    <= FREQ_MIN_RST;
            freq_max_reg    <= FREQ_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_BEEP_ENABLE: beep_enable_reg <= pwdata[0];
                REG_TICK_STEP:   tick_step_reg   <= pwdata[7:0];
                REG_FREQ_MIN:    freq_min_reg    <= pwdata[15:0];
                REG_FREQ_MAX:    freq_max_reg    <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (idx)
            REG_BEEP_ENABLE: prdata = {31'd0, beep_enable_reg};
            REG_TICK_STEP:   prdata = {24'd0, tick_step_reg};
            REG_FREQ_MIN:    prdata = {16'd0, freq_min_reg};
            REG_FREQ_MAX:    prdata = {16'd0, freq_max_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.beep_enable  = beep_enable_reg;
    assign cfg.tick_step_ms = tick_step_reg;
    assign cfg.freq_min_hz  = freq_min_reg;
    assign cfg.freq_max_hz  = freq_max_reg;

endmodule

@@ rtl/bps_ctrl.sv @@
// Control state machine of the buzzer pattern sequencer.
// Depends on bps_pkg; drives the datapath through bps_cmd_t and reads bps_status_t.
module bps_ctrl import bps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  bps_status_t status,
    output bps_cmd_t    cmd
);

    bps_state_t state_reg;
    bps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    // Only the first tick after arming needs the compare value.
                    if (command == CMD_TICK && status.armed)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/bps_datapath.sv @@
// Datapath of the buzzer pattern sequencer: sequence state, serial divider
// for the tone compare value and the output register. Depends on bps_pkg.
module bps_datapath import bps_pkg::*;
#(
    parameter int unsigned CLOCK_HZ = CLOCK_HZ_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  bps_cfg_t    cfg,
    input  bps_cmd_t    cmd,
    output bps_status_t status,
    input  logic        command,
    input  logic [15:0] tone_hz,
    input  logic [15:0] beep_ms,
    input  logic [15:0] gap_ms,
    input  logic [7:0]  repeat_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tone_active,
    output logic [7:0]  tone_compare,
    output logic [1:0]  seq_phase,
    output logic [7:0]  repeats_left
);

    // floor(CLOCK_HZ / (64 * f)) equals floor(floor(CLOCK_HZ / 64) / f).
    localparam int unsigned DIVIDEND = CLOCK_HZ / TONE_PRESCALE;
    localparam int unsigned DIV_W    = $clog2(DIVIDEND + 1);
    localparam int unsigned CNT_W    = $clog2(DIV_W + 1);
    localparam logic [DIV_W-1:0] DIVIDEND_V = DIV_W'(DIVIDEND);
    localparam logic [DIV_W-1:0] QUO_SAT    = DIV_W'(256);
    localparam logic [DIV_W-1:0] QUO_ONE    = DIV_W'(1);

    // Latched item.
    logic        item_cmd_reg;
    logic [15:0] item_hz_reg;
    logic [15:0] item_beep_reg;
    logic [15:0] item_gap_reg;
    logic [7:0]  item_rep_reg;

    // Sequence state.
    bps_phase_t  phase_reg, phase_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] freq_reg, freq_next;
    logic [15:0] beep_len_reg, beep_len_next;
    logic [15:0] gap_len_reg, gap_len_next;
    logic [7:0]  rep_left_reg, rep_left_next;
    logic [7:0]  compare_reg, compare_next;
    logic        tone_on_reg, tone_on_next;

    // Divider.
    logic [DIV_W-1:0] quo_reg;
    logic [15:0]      rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [16:0]      rem_shift;
    logic             rem_ge;
    logic [16:0]      rem_diff;

    // Output register.
    logic        out_valid_reg;
    logic        out_tone_reg;
    logic [7:0]  out_compare_reg;
    logic [1:0]  out_phase_reg;
    logic [7:0]  out_rep_reg;

    logic [15:0]      freq_lo;
    logic [15:0]      freq_clamped;
    logic [15:0]      limit;
    logic [16:0]      elapsed_sum;
    logic [DIV_W-1:0] quo_dec;
    logic [7:0]       compare_sat;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_cmd_reg  <= command;
            item_hz_reg   <= tone_hz;
            item_beep_reg <= beep_ms;
            item_gap_reg  <= gap_ms;
            item_rep_reg  <= repeat_count;
        end
    end

    // Restoring division, one quotient bit per cycle.
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, freq_reg};
    assign rem_diff  = rem_shift - {1'b0, freq_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= DIVIDEND_V;
            rem_reg <= 16'd0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[15:0] : rem_shift[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= CNT_W'(DIV_W);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign quo_dec = quo_reg - QUO_ONE;

    always_comb
    begin
        if (freq_reg == 16'd0)
        begin
            compare_sat = 8'hFF;
        end
        else if (quo_reg == '0)
        begin
            compare_sat = 8'd0;
        end
        else if (quo_reg > QUO_SAT)
        begin
            compare_sat = 8'hFF;
        end
        else
        begin
            compare_sat = quo_dec[7:0];
        end
    end

    // Raise to the minimum first, then lower to the maximum.
    assign freq_lo      = (item_hz_reg < cfg.freq_min_hz) ? cfg.freq_min_hz : item_hz_reg;
    assign freq_clamped = (freq_lo > cfg.freq_max_hz) ? cfg.freq_max_hz : freq_lo;
    assign limit        = (phase_reg == PH_BEEP) ? beep_len_reg : gap_len_reg;
    assign elapsed_sum  = {1'b0, elapsed_reg} + {9'd0, cfg.tick_step_ms};

    always_comb
    begin
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        freq_next     = freq_reg;
        beep_len_next = beep_len_reg;
        gap_len_next  = gap_len_reg;
        rep_left_next = rep_left_reg;
        compare_next  = compare_reg;
        tone_on_next  = tone_on_reg;
        if (item_cmd_reg == CMD_START)
        begin
            if (cfg.beep_enable)
            begin
                tone_on_next  = 1'b0;
                freq_next     = freq_clamped;
                beep_len_next = item_beep_reg;
                gap_len_next  = item_gap_reg;
                rep_left_next = item_rep_reg;
                phase_next    = PH_ARMED;
            end
        end
        else
        begin
            case (phase_reg) inside
                PH_ARMED:
                begin
                    compare_next = compare_sat;
                    phase_next   = PH_BEEP;
                    tone_on_next = 1'b1;
                    elapsed_next = 16'd0;
                end
                PH_BEEP, PH_PAUSE:
                begin
                    if (limit > elapsed_reg)
                    begin
                        elapsed_next = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
                    end
                    else
                    begin
                        elapsed_next = 16'd0;
                        if (phase_reg == PH_BEEP)
                        begin
                            tone_on_next = 1'b0;
                            phase_next   = (rep_left_reg != 8'd0) ? PH_PAUSE : PH_STOP;
                        end
                        else
                        begin
                            phase_next    = PH_BEEP;
                            tone_on_next  = 1'b1;
                            rep_left_next = rep_left_reg - 8'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_STOP;
            elapsed_reg  <= 16'd0;
            freq_reg     <= 16'd0;
            beep_len_reg <= 16'd0;
            gap_len_reg  <= 16'd0;
            rep_left_reg <= 8'd0;
            compare_reg  <= 8'd0;
            tone_on_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            freq_reg     <= freq_next;
            beep_len_reg <= beep_len_next;
            gap_len_reg  <= gap_len_next;
            rep_left_reg <= rep_left_next;
            compare_reg  <= compare_next;
            tone_on_reg  <= tone_on_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_tone_reg    <= tone_on_next;
            out_compare_reg <= compare_next;
            out_phase_reg   <= phase_next;
            out_rep_reg     <= rep_left_next;
        end
    end

    assign status.armed    = (phase_reg == PH_ARMED);
    assign status.div_done = (cnt_reg == '0);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign tone_active  = out_tone_reg;
    assign tone_compare = out_compare_reg;
    assign seq_phase    = out_phase_reg;
    assign repeats_left = out_rep_reg;

endmodule

@@ rtl/beep_pattern_sequencer.sv @@
// Buzzer pattern sequencer: start and tick items in, one status item out per item.
// Top level; depends on bps_pkg, bps_cfg, bps_ctrl and bps_datapath.
//
// Input channel (in_valid/in_stall): command 1 starts a pattern from tone_hz,
// beep_ms, gap_ms and repeat_count; command 0 is a time tick. Output channel
// (out_valid/out_stall): one item per input item with tone_active,
// tone_compare, seq_phase and repeats_left after that item.
// One item is in work at a time. A start item or an ordinary tick goes from the
// idle state through the commit state into the output register; the first tick
// after a start runs the serial divider, one quotient bit per cycle, before the
// commit state.
// The next item is taken in the cycle after the result is registered.
// A result may wait in the output register while the next item is worked on;
// that item then holds until the receiver takes the waiting result.
// Reset stops the sequence, clears the sequence state (tone off) and out_valid and
// loads the register defaults (enabled, 10 ms step, 500 Hz to 8000 Hz). The user
// writes registers over the APB port only while no item is in work (not enforced).
module beep_pattern_sequencer import bps_pkg::*;
#(
    parameter int unsigned CLOCK_HZ = CLOCK_HZ_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic [15:0]       tone_hz,
    input  logic [15:0]       beep_ms,
    input  logic [15:0]       gap_ms,
    input  logic [7:0]        repeat_count,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              tone_active,
    output logic [7:0]        tone_compare,
    output logic [1:0]        seq_phase,
    output logic [7:0]        repeats_left
);

    bps_cfg_t    cfg;
    bps_cmd_t    cmd;
    bps_status_t status;

    bps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    bps_datapath #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .command      (command),
        .tone_hz      (tone_hz),
        .beep_ms      (beep_ms),
        .gap_ms       (gap_ms),
        .repeat_count (repeat_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tone_active  (tone_active),
        .tone_compare (tone_compare),
        .seq_phase    (seq_phase),
        .repeats_left (repeats_left)
    );

endmodule

@@ rtl/bps_checker.sv @@
// Port-level checker of the buzzer pattern sequencer, bound to the top level.
// Depends on bps_pkg and the assertion macros in beep_pattern_sequencer_assert.svh.
`include "beep_pattern_sequencer_assert.svh"

module bps_checker import bps_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       tone_active,
    input logic [7:0] tone_compare,
    input logic [1:0] seq_phase,
    input logic [7:0] repeats_left
);

    // A held result keeps its valid and its fields.
    `BPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(tone_active) && $stable(tone_compare) && $stable(seq_phase) && $stable(repeats_left), "output item changed while stalled")

    // Only one item is in work at a time.
    `BPS_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item accepted while busy")

    // The tone runs exactly in the beep phase.
    `BPS_ASSERT_IMP(a_tone_phase, out_valid, tone_active == (seq_phase == PH_BEEP), "tone state disagrees with phase")

    // The sequence stops only once no repeats remain.
    `BPS_ASSERT_IMP(a_stop_empty, out_valid && seq_phase == PH_STOP, repeats_left == 8'd0, "stopped with repeats left")

endmodule

bind beep_pattern_sequencer bps_checker u_bps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tone_active  (tone_active),
    .tone_compare (tone_compare),
    .seq_phase    (seq_phase),
    .repeats_left (repeats_left)
);

@@ tb/sv/beep_pattern_sequencer_test.sv @@
// Self-checking testbench for the buzzer pattern sequencer: directed and random
// start/tick items against a built-in predictor, with random gaps on both channels.
// Depends on bps_pkg and the beep_pattern_sequencer RTL.
`timescale 1ns / 1ps

module beep_pattern_sequencer_test;
    import bps_pkg::*;

    localparam int unsigned SEQ_CLOCK_HZ   = CLOCK_HZ_DEFAULT;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          MAX_REPORTS    = 10;
    localparam int          SIDE_SEND      = 0;
    localparam int          SIDE_RECV      = 1;

    typedef struct packed {
        logic        command;
        logic [15:0] tone_hz;
        logic [15:0] beep_ms;
        logic [15:0] gap_ms;
        logic [7:0]  repeat_count;
    } beep_request_t;

    typedef struct packed {
        logic        tone_active;
        logic [7:0]  tone_compare;
        bps_phase_t  seq_phase;
        logic [7:0]  repeats_left;
    } beep_status_t;

    typedef struct {
        bps_phase_t  phase;
        logic [15:0] elapsed;
        logic [15:0] freq;
        logic [15:0] beep_len;
        logic [15:0] gap_len;
        logic [7:0]  repeats;
        logic [7:0]  compare;
        logic        tone_on;
    } buzzer_state_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic              command      = 1'b0;
    logic [15:0]       tone_hz      = '0;
    logic [15:0]       beep_ms      = '0;
    logic [15:0]       gap_ms       = '0;
    logic [7:0]        repeat_count = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic              tone_active;
    logic [7:0]        tone_compare;
    logic [1:0]        seq_phase;
    logic [7:0]        repeats_left;

    beep_request_t  pending_q[$];
    beep_status_t   status_q[$];
    bps_cfg_t       cfg;
    buzzer_state_t  bz;
    bit             no_idle[2];

    int idle_left;
    int stall_left;
    int quiet_cycles;
    int error_count;
    int n_queued;
    int n_results;
    int n_starts;
    int n_ignored;
    int n_ticks;
    int n_finished;
    int n_saturated;
    int n_settings;

    beep_pattern_sequencer #(.CLOCK_HZ(SEQ_CLOCK_HZ)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .tone_hz      (tone_hz),
        .beep_ms      (beep_ms),
        .gap_ms       (gap_ms),
        .repeat_count (repeat_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tone_active  (tone_active),
        .tone_compare (tone_compare),
        .seq_phase    (seq_phase),
        .repeats_left (repeats_left)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] toggle_compare(logic [15:0] freq);
        longint unsigned quot;
        if (freq == 16'd0)
            return 8'hFF;
        quot = 64'(SEQ_CLOCK_HZ) / (64'(TONE_PRESCALE) * 64'(freq));
        if (quot == 0)
            return 8'h00;
        quot = quot - 1;
        return (quot > 255) ? 8'hFF : quot[7:0];
    endfunction

    // Advances the predicted sequencer by one item and returns the status it shows.
    function automatic beep_status_t predict_status(beep_request_t req);
        beep_status_t st;
        logic [15:0]  f;
        logic [15:0]  limit;
        logic [16:0]  advanced;
        if (req.command == CMD_START) begin
            if (cfg.beep_enable) begin
                f = req.tone_hz;
                if (f < cfg.freq_min_hz)
                    f = cfg.freq_min_hz;
                if (f > cfg.freq_max_hz)
                    f = cfg.freq_max_hz;
                bz.tone_on  = 1'b0;
                bz.freq     = f;
                bz.beep_len = req.beep_ms;
                bz.gap_len  = req.gap_ms;
                bz.repeats  = req.repeat_count;
                bz.phase    = PH_ARMED;
                n_starts++;
            end else begin
                n_ignored++;
            end
        end else begin
            n_ticks++;
            if (bz.phase == PH_ARMED) begin
                bz.compare = toggle_compare(bz.freq);
                bz.phase   = PH_BEEP;
                bz.tone_on = 1'b1;
                bz.elapsed = 16'd0;
            end else if (bz.phase == PH_BEEP || bz.phase == PH_PAUSE) begin
                limit = (bz.phase == PH_BEEP) ? bz.beep_len : bz.gap_len;
                if (limit > bz.elapsed) begin
                    advanced = {1'b0, bz.elapsed} + 17'(cfg.tick_step_ms);
                    if (advanced[16])
                        n_saturated++;
                    bz.elapsed = advanced[16] ? 16'hFFFF : advanced[15:0];
                end else begin
                    bz.elapsed = 16'd0;
                    if (bz.phase == PH_BEEP) begin
                        bz.tone_on = 1'b0;
                        bz.phase   = (bz.repeats != 8'd0) ? PH_PAUSE : PH_STOP;
                        if (bz.phase == PH_STOP)
                            n_finished++;
                    end else begin
                        bz.phase   = PH_BEEP;
                        bz.tone_on = 1'b1;
                        bz.repeats = bz.repeats - 8'd1;
                    end
                end
            end
        end
        st.tone_active  = bz.tone_on;
        st.tone_compare = bz.compare;
        st.seq_phase    = bz.phase;
        st.repeats_left = bz.repeats;
        return st;
    endfunction

    function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("result %0d: %s expected %0d, got %0d", n_results, what, want, got);
    endfunction

    // Each side alternates between stretches of random gaps and stretches without any.
    function automatic int draw_wait(int side);
        if ($urandom_range(0, 31) == 0)
            no_idle[side] = !no_idle[side];
        return no_idle[side] ? 0 : int'($urandom_range(0, 6));
    endfunction

    // Input side: presents queued items, holds them while stalled, then idles a drawn gap.
    always @(posedge clk)
    begin : item_driver
        beep_request_t req;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            idle_left <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                req = {command, tone_hz, beep_ms, gap_ms, repeat_count};
                status_q.push_back(predict_status(req));
            end
            if (!(in_valid && in_stall)) begin
                if (idle_left > 0) begin
                    in_valid  <= 1'b0;
                    idle_left <= idle_left - 1;
                end else if (pending_q.size() != 0) begin
                    req = pending_q.pop_front();
                    command      <= req.command;
                    tone_hz      <= req.tone_hz;
                    beep_ms      <= req.beep_ms;
                    gap_ms       <= req.gap_ms;
                    repeat_count <= req.repeat_count;
                    in_valid     <= 1'b1;
                    idle_left    <= draw_wait(SIDE_SEND);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks every accepted result, then stalls for a drawn number of cycles.
    always @(posedge clk)
    begin : status_monitor
        beep_status_t want;
        int           n;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            n_results++;
            if (status_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected", n_results);
            end else begin
                want = status_q.pop_front();
                if (tone_active != want.tone_active)
                    note_mismatch("tone_active", want.tone_active, tone_active);
                if (tone_compare != want.tone_compare)
                    note_mismatch("tone_compare", want.tone_compare, tone_compare);
                if (seq_phase != want.seq_phase)
                    note_mismatch("seq_phase", want.seq_phase, seq_phase);
                if (repeats_left != want.repeats_left)
                    note_mismatch("repeats_left", want.repeats_left, repeats_left);
            end
            n = draw_wait(SIDE_RECV);
            stall_left <= n;
            out_stall  <= (n != 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_cycle(input logic wr, input bps_reg_idx_t idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes one register, mirrors it in the predictor and reads it back.
    task automatic program_reg(bps_reg_idx_t idx, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] rdata;
        case (idx)
            REG_BEEP_ENABLE: mask = 32'h0000_0001;
            REG_TICK_STEP:   mask = 32'h0000_00FF;
            default:         mask = 32'h0000_FFFF;
        endcase
        apb_cycle(1'b1, idx, value & mask, rdata);
        case (idx)
            REG_BEEP_ENABLE: cfg.beep_enable  = value[0];
            REG_TICK_STEP:   cfg.tick_step_ms = value[7:0];
            REG_FREQ_MIN:    cfg.freq_min_hz  = value[15:0];
            default:         cfg.freq_max_hz  = value[15:0];
        endcase
        apb_cycle(1'b0, idx, 32'd0, rdata);
        if ((rdata & mask) != (value & mask)) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("register %s read back %0h, expected %0h",
                         idx.name(), rdata & mask, value & mask);
        end
    endtask

    task automatic set_config(logic en, logic [7:0] tick_len, logic [15:0] fmin,
                              logic [15:0] fmax);
        program_reg(REG_BEEP_ENABLE, 32'(en));
        program_reg(REG_TICK_STEP, 32'(tick_len));
        program_reg(REG_FREQ_MIN, 32'(fmin));
        program_reg(REG_FREQ_MAX, 32'(fmax));
        n_settings++;
        @(negedge clk);
    endtask

    // Sampled on the falling edge so the queues and handshakes have settled.
    task automatic wait_for_idle();
        while (pending_q.size() != 0 || in_valid || status_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic beep_request_t random_request(logic cmd);
        beep_request_t r;
        r.command      = cmd;
        r.tone_hz      = 16'($urandom);
        r.beep_ms      = 16'($urandom);
        r.gap_ms       = 16'($urandom);
        r.repeat_count = 8'($urandom);
        return r;
    endfunction

    task automatic q_item(beep_request_t r);
        pending_q.push_back(r);
        n_queued++;
    endtask

    task automatic q_start(logic [15:0] tone, logic [15:0] beep_len, logic [15:0] gap_len,
                           logic [7:0] reps);
        beep_request_t r;
        r.command      = CMD_START;
        r.tone_hz      = tone;
        r.beep_ms      = beep_len;
        r.gap_ms       = gap_len;
        r.repeat_count = reps;
        q_item(r);
    endtask

    task automatic q_ticks(int n);
        repeat (n) q_item(random_request(CMD_TICK));
    endtask

    // A start followed by about enough ticks to play the pattern out; some are cut short.
    task automatic queue_pattern();
        int          tick_len;
        int          beep_len;
        int          gap_len;
        int          reps;
        int          ticks;
        logic [15:0] tone;
        tick_len = (cfg.tick_step_ms == 8'd0) ? 1 : int'(cfg.tick_step_ms);
        case ($urandom_range(0, 3))
            0:       tone = 16'($urandom);
            1:       tone = 16'($urandom_range(cfg.freq_min_hz, cfg.freq_max_hz));
            2:       tone = 16'($urandom_range(0, 600));
            default: tone = 16'(65535 - $urandom_range(0, 200));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            beep_len = $urandom_range(0, 65535);
            gap_len  = $urandom_range(0, 65535);
        end else begin
            beep_len = $urandom_range(0, 4 * tick_len);
            gap_len  = $urandom_range(0, 3 * tick_len);
        end
        reps = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        ticks = 1 + (reps + 1) * (beep_len / tick_len + 2) + reps * (gap_len / tick_len + 2);
        if (ticks > 40)
            ticks = $urandom_range(20, 40);
        if ($urandom_range(0, 5) == 0)
            ticks = $urandom_range(0, ticks);
        q_start(tone, 16'(beep_len), 16'(gap_len), 8'(reps));
        q_ticks(ticks);
    endtask

    task automatic run_random(int count);
        int stop_at;
        stop_at = n_queued + count;
        while (n_queued < stop_at) begin
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 3)) q_item(random_request(1'($urandom)));
            else
                queue_pattern();
        end
        wait_for_idle();
    endtask

    initial
    begin : stimulus
        cfg = '{BEEP_ENABLE_RST, TICK_STEP_RST, FREQ_MIN_RST, FREQ_MAX_RST};
        bz  = '{PH_STOP, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: tick while stopped, low clamp, zero-length beep, a full
        // pattern with one repeat, high clamp, and a restart while running.
        q_item({CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF});
        q_start(16'd0, 16'd0, 16'd0, 8'd0);
        q_ticks(3);
        q_start(16'hFFFF, 16'd20, 16'd10, 8'd1);
        q_ticks(9);
        q_start(16'd1000, 16'hFFFF, 16'hFFFF, 8'hFF);
        q_ticks(2);
        q_start(16'd2000, 16'd30, 16'd0, 8'd2);
        q_ticks(3);
        wait_for_idle();

        // Widest frequency window and largest step: compare values of zero and 255.
        set_config(1'b1, 8'd255, 16'd1, 16'hFFFF);
        q_start(16'hFFFF, 16'd0, 16'd0, 8'd0);
        q_ticks(2);
        q_start(16'd1, 16'd0, 16'd0, 8'd0);
        q_ticks(2);
        run_random(15);

        // Zero minimum lets a zero frequency through.
        set_config(1'b1, 8'd1, 16'd0, 16'd300);
        q_start(16'd0, 16'd3, 16'd2, 8'd1);
        q_ticks(12);
        run_random(15);

        // Minimum above maximum: the maximum wins.
        set_config(1'b1, 8'd7, 16'hFFFF, 16'd1);
        run_random(15);

        // Disabled: starts leave the running sequence alone.
        set_config(1'b0, 8'd3, 16'd500, 16'd8000);
        run_random(10);

        // Zero step: a phase with length never ends, one without length still does.
        set_config(1'b1, 8'd0, 16'd500, 16'd8000);
        q_start(16'd1000, 16'd50, 16'd0, 8'd0);
        q_ticks(4);
        q_start(16'd1000, 16'd0, 16'd0, 8'd1);
        q_ticks(5);
        wait_for_idle();

        // Long beep that drives the elapsed time into saturation.
        set_config(1'b1, 8'd254, 16'd1, 16'hFFFF);
        q_start(16'd4000, 16'hFFFF, 16'd0, 8'd0);
        q_ticks(262);
        wait_for_idle();

        set_config(1'b1, 8'($urandom_range(2, 254)), 16'($urandom_range(1, 4000)),
                   16'($urandom_range(2000, 65535)));
        run_random(20);

        set_config(1'b1, 8'd10, 16'd500, 16'd8000);
        run_random(20);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (status_q.size() != 0) begin
            error_count++;
            $display("%0d expected results never arrived", status_q.size());
        end
        $display("covered %0d starts (%0d ignored while disabled), %0d ticks, ",
                 n_starts, n_ignored, n_ticks,
                 "%0d patterns played out, %0d elapsed saturations",
                 n_finished, n_saturated);
        $display("checked %0d results over %0d register settings, %0d mismatches",
                 n_results, n_settings + 1, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
